FILE: rtl/cdq_pkg.sv
// Shared constants, command and status codes, and pointer helpers for the
// circular deque. No dependencies.
package cdq_pkg;

    // Capacity and element width of the store.
    localparam int DEPTH  = 16;
    localparam int WIDTH  = 32;

    // Port field widths.
    localparam int CMD_W  = 3;
    localparam int VAL_W  = 32;
    localparam int IDX_W  = 4;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;

    // Derived widths.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam int IW = (CW > IDX_W) ? CW : IDX_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + AW'(1));
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : AW'(p - AW'(1));
    endfunction

endpackage

FILE: rtl/cdq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Standalone; no package dependency.
module cdq_ram #(
    parameter int DATA_W  = 32,
    parameter int DEPTH_N = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH_N > 1) ? $clog2(DEPTH_N) : 1)-1:0] i_waddr,
    input  logic [DATA_W-1:0]                         i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH_N > 1) ? $clog2(DEPTH_N) : 1)-1:0] i_raddr,
    output logic [DATA_W-1:0]                         o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH_N];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/circular_deque_with_index_read.sv
// An accepted word passes through stage one, where the slot RAM read completes, and then the output register.
// The block does not take a new word while the previous one is still in stage one; a new word
// waits until the previous result has left that stage.
// Reset (i_rst_n low at a rising edge): pointers, count and both valid flags clear;
// the slot RAM keeps its contents and needs no clearing pass.
module circular_deque_with_index_read (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Command channel.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [cdq_pkg::CMD_W-1:0]     i_cmd,
    input  logic [cdq_pkg::VAL_W-1:0]     i_value,
    input  logic [cdq_pkg::IDX_W-1:0]     i_index,
    // Result channel.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cdq_pkg::VAL_W-1:0]     o_read_data,
    output logic [cdq_pkg::STAT_W-1:0]    o_status,
    output logic [cdq_pkg::CNT_W-1:0]     o_count
);

    import cdq_pkg::*;

    // Architectural state: front pointer, next free slot at the back, and fill count.
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_cnt,  n_cnt;

    // Stage one holds a decided result while the RAM read completes.
    logic              r_s1_valid;
    logic              r_s1_is_read;
    logic [STAT_W-1:0] r_s1_status;
    logic [CNT_W-1:0]  r_s1_count;

    // Output register.
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_data;
    logic [STAT_W-1:0] r_out_status;
    logic [CNT_W-1:0]  r_out_count;

    logic              accept;
    logic              full;
    logic              empty;
    logic              dec_we;
    logic              dec_re;
    logic [AW-1:0]     dec_waddr;
    logic [STAT_W-1:0] dec_status;
    logic [SW-1:0]     rsum;
    logic [AW-1:0]     raddr;
    logic [WIDTH-1:0]  ram_rdata;

    // A new word is taken only when stage one is empty and the output register
    // will be free by the time stage one hands its result on.
    assign o_in_ready = !r_s1_valid && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    assign full  = (r_cnt == CW'(DEPTH));
    assign empty = (r_cnt == '0);

    // Physical slot of a logical index: head plus index, folded once into range.
    // The index is below the count whenever the read is issued, so one fold is enough.
    assign rsum  = SW'(r_head) + SW'(i_index);
    assign raddr = (rsum >= SW'(DEPTH)) ? AW'(rsum - SW'(DEPTH)) : AW'(rsum);

    // Command decode: next pointers, status, and the single RAM access.
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_cnt      = r_cnt;
        dec_status = ST_OK;
        dec_we     = 1'b0;
        dec_re     = 1'b0;
        dec_waddr  = r_tail;
        case (i_cmd)
            CMD_PUSH_BACK: begin
                if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_we    = 1'b1;
                    dec_waddr = r_tail;
                    n_tail    = wrap_inc(r_tail);
                    n_cnt     = CW'(r_cnt + CW'(1));
                end
            end
            CMD_PUSH_FRONT: begin
                if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_we    = 1'b1;
                    dec_waddr = wrap_dec(r_head);
                    n_head    = wrap_dec(r_head);
                    n_cnt     = CW'(r_cnt + CW'(1));
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    dec_status = ST_EMPTY;
                end else begin
                    n_tail = wrap_dec(r_tail);
                    n_cnt  = CW'(r_cnt - CW'(1));
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    dec_status = ST_EMPTY;
                end else begin
                    n_head = wrap_inc(r_head);
                    n_cnt  = CW'(r_cnt - CW'(1));
                end
            end
            CMD_READ: begin
                if (empty) begin
                    dec_status = ST_EMPTY;
                end else if (IW'(i_index) >= IW'(r_cnt)) begin
                    dec_status = ST_RANGE;
                end else begin
                    dec_re = 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_head = '0;
                n_tail = '0;
                n_cnt  = '0;
            end
            default: begin
                // Unused codes leave everything as it is and report ok.
            end
        endcase
    end

    cdq_ram #(
        .DATA_W  (WIDTH),
        .DEPTH_N (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && dec_we),
        .i_waddr (dec_waddr),
        .i_wdata (WIDTH'(i_value)),
        .i_re    (accept && dec_re),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_cnt       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_cnt  <= n_cnt;
            end
            r_s1_valid <= accept;
            // Stage one always finds the output register free when it moves on.
            if (r_s1_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_is_read <= dec_re;
            r_s1_status  <= dec_status;
            r_s1_count   <= CNT_W'(n_cnt);
        end
        if (r_s1_valid) begin
            r_out_data   <= r_s1_is_read ? VAL_W'(ram_rdata) : '0;
            r_out_status <= r_s1_status;
            r_out_count  <= r_s1_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;

endmodule

FILE: rtl/cdq_checker.sv
// Port-level checks for the circular deque, bound to its top level.
// Depends on cdq_pkg for codes and capacity.
module cdq_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  logic [cdq_pkg::CMD_W-1:0]     i_cmd,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [cdq_pkg::VAL_W-1:0]     o_read_data,
    input  logic [cdq_pkg::STAT_W-1:0]    o_status,
    input  logic [cdq_pkg::CNT_W-1:0]     o_count
);

    import cdq_pkg::*;

    // A full report comes only with the queue at capacity.
    a_full_at_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_count == CNT_W'(DEPTH)))
        else $error("full status with count below capacity");

    // An empty report comes only with nothing held.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> (o_count == '0))
        else $error("empty status with nonzero count");

    // Read data is zero on every failed command.
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_read_data == '0))
        else $error("nonzero read data on a failed command");

    // An accepted clear reports an empty queue when its result reaches the output.
    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_cmd == CMD_CLEAR) |-> ##2
        (o_out_valid && o_count == '0 && o_status == ST_OK))
        else $error("clear did not report an empty queue");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_read_data) && $stable(o_status) && $stable(o_count)))
        else $error("stalled result changed");

endmodule

bind circular_deque_with_index_read cdq_checker u_cdq_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for circular_deque_with_index_read: directed table plus
// random command traffic, checked against a local deque model. Depends on cdq_pkg.
module testbench;
    import cdq_pkg::*;

    // Codes 6 and 7 are not assigned to any operation; the block must ignore them.
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam int RANDOM_PER_PHASE = 350;
    localparam int DRAIN_CYCLES     = 12;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
    } t_deque_word;

    typedef struct packed {
        logic [VAL_W-1:0]  read_data;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
    } t_deque_result;

    // One row of the directed table. A row is sent reps times, with the value
    // stepped by one each time. Where fixed is set the result is the one typed
    // in the row; otherwise it comes from the deque model.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
        logic [4:0]       reps;
        logic             fixed;
        t_deque_result    want;
    } t_stim_row;

    localparam int NUM_ROWS = 21;
    localparam t_stim_row DIRECTED_ROWS [NUM_ROWS] = '{
        // Pops and reads on the empty deque after reset.
        '{CMD_POP_BACK,   32'h0000_0000, 4'd0,  5'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
        '{CMD_POP_FRONT,  32'h0000_0000, 4'd0,  5'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
        '{CMD_READ,       32'h0000_0000, 4'd0,  5'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
        // Unassigned codes change nothing, even with every payload bit set.
        '{CMD_RSVD_6,     32'hFFFF_FFFF, 4'd15, 5'd1, 1'b1, '{32'h0, ST_OK,    5'd0}},
        '{CMD_RSVD_7,     32'hFFFF_FFFF, 4'd15, 5'd1, 1'b1, '{32'h0, ST_OK,    5'd0}},
        // Push at both ends; the front push wraps the head pointer below zero.
        '{CMD_PUSH_BACK,  32'hFFFF_FFFF, 4'd0,  5'd1, 1'b1, '{32'h0, ST_OK,    5'd1}},
        '{CMD_PUSH_FRONT, 32'h0000_0000, 4'd0,  5'd1, 1'b1, '{32'h0, ST_OK,    5'd2}},
        '{CMD_READ,       32'h0000_0000, 4'd1,  5'd1, 1'b1, '{32'hFFFF_FFFF, ST_OK, 5'd2}},
        '{CMD_READ,       32'h0000_0000, 4'd0,  5'd1, 1'b1, '{32'h0, ST_OK,    5'd2}},
        // Index at and beyond the count is out of range.
        '{CMD_READ,       32'h0000_0000, 4'd2,  5'd1, 1'b1, '{32'h0, ST_RANGE, 5'd2}},
        '{CMD_READ,       32'h0000_0000, 4'd15, 5'd1, 1'b1, '{32'h0, ST_RANGE, 5'd2}},
        // Fill to capacity from both ends, then try to push past it.
        '{CMD_PUSH_FRONT, 32'hA5A5_0000, 4'd0,  5'd7, 1'b0, '0},
        '{CMD_PUSH_BACK,  32'h5A5A_0000, 4'd0,  5'd7, 1'b0, '0},
        '{CMD_PUSH_BACK,  32'h1234_5678, 4'd0,  5'd1, 1'b1, '{32'h0, ST_FULL,  5'd16}},
        '{CMD_PUSH_FRONT, 32'h8765_4321, 4'd0,  5'd1, 1'b1, '{32'h0, ST_FULL,  5'd16}},
        '{CMD_READ,       32'h0000_0000, 4'd15, 5'd1, 1'b0, '0},
        '{CMD_POP_BACK,   32'h0000_0000, 4'd0,  5'd1, 1'b1, '{32'h0, ST_OK,    5'd15}},
        '{CMD_POP_FRONT,  32'h0000_0000, 4'd0,  5'd1, 1'b1, '{32'h0, ST_OK,    5'd14}},
        '{CMD_CLEAR,      32'h0000_0000, 4'd0,  5'd1, 1'b1, '{32'h0, ST_OK,    5'd0}},
        // After a clear, a front push then a back pop wraps the tail pointer.
        '{CMD_PUSH_FRONT, 32'hDEAD_BEEF, 4'd0,  5'd1, 1'b1, '{32'h0, ST_OK,    5'd1}},
        '{CMD_POP_BACK,   32'h0000_0000, 4'd0,  5'd1, 1'b1, '{32'h0, ST_OK,    5'd0}}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [CMD_W-1:0]   i_cmd = '0;
    logic [VAL_W-1:0]   i_value = '0;
    logic [IDX_W-1:0]   i_index = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [VAL_W-1:0]   o_read_data;
    logic [STAT_W-1:0]  o_status;
    logic [CNT_W-1:0]   o_count;

    circular_deque_with_index_read dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .i_index     (i_index),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_read_data (o_read_data),
        .o_status    (o_status),
        .o_count     (o_count)
    );

    // Local copy of the deque: element store, front and back pointers, fill level.
    logic [VAL_W-1:0] slot_mem [DEPTH];
    logic [AW-1:0]    front_ptr;
    logic [AW-1:0]    back_ptr;
    int               fill_level;

    // Results still owed by the block, oldest first.
    t_deque_result pending_results [$];
    int            mismatch_count = 0;

    // Idle percentages for the current phase of the run.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Random traffic alternates between a filling bias and a draining bias so
    // that the fill level sweeps from empty to full and back again.
    bit filling = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies one command to the local deque and returns the result it gives.
    function automatic t_deque_result deque_apply(input t_deque_word w);
        t_deque_result r;
        r = '0;
        r.status = ST_OK;
        case (w.cmd)
            CMD_PUSH_BACK: begin
                if (fill_level >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot_mem[back_ptr] = w.value;
                    back_ptr = AW'((int'(back_ptr) + 1) % DEPTH);
                    fill_level++;
                end
            end
            CMD_PUSH_FRONT: begin
                if (fill_level >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    front_ptr = AW'((int'(front_ptr) + DEPTH - 1) % DEPTH);
                    slot_mem[front_ptr] = w.value;
                    fill_level++;
                end
            end
            CMD_POP_BACK: begin
                if (fill_level == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    back_ptr = AW'((int'(back_ptr) + DEPTH - 1) % DEPTH);
                    fill_level--;
                end
            end
            CMD_POP_FRONT: begin
                if (fill_level == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    front_ptr = AW'((int'(front_ptr) + 1) % DEPTH);
                    fill_level--;
                end
            end
            CMD_READ: begin
                if (fill_level == 0) begin
                    r.status = ST_EMPTY;
                end else if (int'(w.index) >= fill_level) begin
                    r.status = ST_RANGE;
                end else begin
                    r.read_data = slot_mem[AW'((int'(front_ptr) + int'(w.index)) % DEPTH)];
                end
            end
            CMD_CLEAR: begin
                front_ptr = '0;
                back_ptr = '0;
                fill_level = 0;
            end
            default: begin
            end
        endcase
        r.count = CNT_W'(fill_level);
        return r;
    endfunction

    // Draws one random command. Reads mostly land on held entries, with the
    // rest spread over the whole index range to reach the out-of-range case.
    function automatic t_deque_word random_word();
        t_deque_word w;
        int roll;
        int push_cut;
        roll = $urandom_range(99);
        w.value = $urandom();
        case ($urandom_range(9))
            0: w.value = '0;
            1: w.value = '1;
            default: begin
            end
        endcase
        w.index = IDX_W'($urandom_range(15));
        if (filling && fill_level == DEPTH && $urandom_range(3) == 0) begin
            filling = 1'b0;
        end else if (!filling && fill_level == 0 && $urandom_range(3) == 0) begin
            filling = 1'b1;
        end
        push_cut = filling ? 55 : 16;
        if (roll < push_cut / 2) begin
            w.cmd = CMD_PUSH_BACK;
        end else if (roll < push_cut) begin
            w.cmd = CMD_PUSH_FRONT;
        end else if (roll < (push_cut + 71) / 2) begin
            w.cmd = CMD_POP_BACK;
        end else if (roll < 71) begin
            w.cmd = CMD_POP_FRONT;
        end else if (roll < 97) begin
            w.cmd = CMD_READ;
            if (fill_level > 0 && $urandom_range(4) != 0) begin
                w.index = IDX_W'($urandom_range(fill_level - 1));
            end
        end else if (roll < 98) begin
            w.cmd = CMD_CLEAR;
        end else begin
            w.cmd = (roll == 98) ? CMD_RSVD_6 : CMD_RSVD_7;
        end
        return w;
    endfunction

    // Offers one word on the command channel. Called just after a falling edge
    // and returns just after the falling edge that follows acceptance, so that
    // back-to-back words keep valid high without a glitch. The expected result
    // is queued at the accepting edge: either the typed one or the model's.
    task automatic send_word(input t_deque_word w, input bit fixed, input t_deque_result want);
        t_deque_result predicted;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_cmd <= w.cmd;
        i_value <= w.value;
        i_index <= w.index;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = deque_apply(w);
        pending_results.push_back(fixed ? want : predicted);
        @(negedge i_clk);
    endtask

    // The result channel stalls at random, decided at each falling edge.
    initial begin
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every accepted result is checked field by field against the oldest
    // expectation; a result with nothing owed is itself a failure.
    always @(posedge i_clk) begin : result_check
        t_deque_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected word: read_data %h status %0d count %0d",
                       o_read_data, o_status, o_count);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, o_read_data);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_deque_word w;
        int          phase;
        int          n;
        int          k;
        int          idle_plan [4][2];

        // Sender idle and receiver stall percentages for each phase.
        idle_plan = '{'{0, 0}, '{88, 0}, '{0, 88}, '{37, 37}};

        for (n = 0; n < DEPTH; n++) begin
            slot_mem[n] = '0;
        end
        front_ptr = '0;
        back_ptr = '0;
        fill_level = 0;

        // Synchronous reset held low from the start, released on a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, sent with no idling on either side.
        for (n = 0; n < NUM_ROWS; n++) begin
            for (k = 0; k < int'(DIRECTED_ROWS[n].reps); k++) begin
                w.cmd = DIRECTED_ROWS[n].cmd;
                w.value = DIRECTED_ROWS[n].value + VAL_W'(k);
                w.index = DIRECTED_ROWS[n].index;
                send_word(w, DIRECTED_ROWS[n].fixed, DIRECTED_ROWS[n].want);
            end
        end

        // Random traffic, one block per idling phase.
        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = idle_plan[phase][0];
            recv_stall_pct = idle_plan[phase][1];
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                w = random_word();
                send_word(w, 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;
        recv_stall_pct = 0;

        // Let the owed results drain, then keep watching the result channel for strays.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[circular_deque_with_index_read] OK");
        end else begin
            $display("[circular_deque_with_index_read] ERROR");
        end
        $finish;
    end

    // Watchdog: a time limit far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("[circular_deque_with_index_read] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/circular_deque_with_index_read.sv
rtl/cdq_checker.sv
tb/testbench.sv
